// ----- hw/rtl/bspline_curve_evaluator_core_assert.svh -----
// Assertion helpers for the B-spline evaluator.
// Every check is sampled on the rising edge of clk and is held off during reset.
`ifndef BSPLINE_CURVE_EVALUATOR_CORE_ASSERT_SVH
`define BSPLINE_CURVE_EVALUATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BSPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hw/rtl/bspc_pkg.sv -----
package bspc_pkg;

  // Number formats.
  localparam int FRAC_BITS  = 16;
  localparam int TW         = 17;
  localparam logic [TW-1:0] ONE = TW'(1) << FRAC_BITS;

  // Sizes of the stores.
  localparam int MAX_POINTS = 32;
  localparam int MAX_DEGREE = 7;
  localparam int PT_AW      = 5;
  localparam int KNOT_DEPTH = MAX_POINTS + MAX_DEGREE + 2;
  localparam int KNOT_AW    = 6;
  localparam int W_DEPTH    = MAX_DEGREE + 1;

  // Shared divider widths: a 34-bit dividend over a 17-bit divisor.
  localparam int DIVD_W = 34;
  localparam int DIVS_W = 17;

  // Coordinate accumulator; the sum of 32 weighted points cannot overflow it.
  localparam int ACC_W = 56;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sd2147483648);

  // Configuration port.
  localparam int ADDR_W = 3;
  localparam logic REG_DEGREE = 1'b0;
  localparam logic REG_COUNT  = 1'b1;

  // Request codes.
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_EVAL  = 2'd1;
  localparam logic [1:0] REQ_BUILD = 2'd2;

  // One control point as held in the point store.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  // Divider request and response.
  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVD_W-1:0] quot;
  } div_rsp_t;

  // Floor division of the accumulator by ONE, then saturation to 32 bits.
  function automatic logic signed [31:0] finish_coord(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] q;
    q = acc >>> FRAC_BITS;
    if (q > SAT_HI) begin
      q = SAT_HI;
    end else if (q < SAT_LO) begin
      q = SAT_LO;
    end
    return q[31:0];
  endfunction

endpackage

// ----- hw/rtl/bspc_req_if.sv -----
interface bspc_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [4:0]         point_index;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic [16:0]        param_t;
  logic [5:0]         segments;

  modport source (
    output valid, req_type, point_index, point_x, point_y, point_z, param_t, segments,
    input  ready
  );
  modport sink (
    input  valid, req_type, point_index, point_x, point_y, point_z, param_t, segments,
    output ready
  );
endinterface

// ----- hw/rtl/bspc_rsp_if.sv -----
interface bspc_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] curve_x;
  logic signed [31:0] curve_y;
  logic signed [31:0] curve_z;
  logic               degenerate;
  logic               last;

  modport source (
    output valid, curve_x, curve_y, curve_z, degenerate, last,
    input  ready
  );
  modport sink (
    input  valid, curve_x, curve_y, curve_z, degenerate, last,
    output ready
  );
endinterface

// ----- hw/rtl/bspc_div.sv -----
module bspc_div (
  input  logic               clk,
  input  logic               rst,
  input  bspc_pkg::div_req_t req,
  output bspc_pkg::div_rsp_t rsp
);

  localparam int DW = bspc_pkg::DIVD_W;
  localparam int SW = bspc_pkg::DIVS_W;
  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic          done;
  logic [DW-1:0] quo;
  logic [SW-1:0] rem;
  logic [SW-1:0] dsr;
  logic [CW-1:0] cnt;
  logic [SW:0]   trial;
  logic          fits;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    trial = {rem, quo[DW-1]};
    fits  = trial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        quo  <= req.dividend;
        dsr  <= req.divisor;
        rem  <= '0;
        cnt  <= CW'(DW);
      end else if (busy) begin
        rem <= fits ? SW'(trial - {1'b0, dsr}) : trial[SW-1:0];
        quo <= {quo[DW-2:0], fits};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quo;

endmodule

// ----- hw/rtl/bspline_curve_evaluator_core.sv -----
// Clamped uniform B-spline curve evaluator, one item at a time.
// Evaluate at t = 0 or t >= 1 returns the first or last point. Interior evaluate: knot build
// (one division per interior knot on the 34-step shared divider) plus, for each
// point, a degree-0 pass and, for points whose span holds t, p(p+1)/2 raises of up to two
// divisions each. A build makes the knots once, then for each sample divides for t and evaluates as above.
// Reset (synchronous, active high): degree 3, point count 0, no result pending.
module bspline_curve_evaluator_core (
  input  logic                        clk,
  input  logic                        rst,
  bspc_req_if.sink                    cmd,
  bspc_rsp_if.source                  res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bspc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int TW  = bspc_pkg::TW;
  localparam int KAW = bspc_pkg::KNOT_AW;
  localparam int PAW = bspc_pkg::PT_AW;
  localparam int DW  = bspc_pkg::DIVD_W;
  localparam int SW  = bspc_pkg::DIVS_W;
  localparam int AW  = bspc_pkg::ACC_W;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_EVAL    = 5'd1;
  localparam logic [4:0] S_DEG     = 5'd2;
  localparam logic [4:0] S_END_RD  = 5'd3;
  localparam logic [4:0] S_END_OUT = 5'd4;
  localparam logic [4:0] S_KNOT    = 5'd5;
  localparam logic [4:0] S_KNOT_W  = 5'd6;
  localparam logic [4:0] S_TDIV    = 5'd7;
  localparam logic [4:0] S_TWAIT   = 5'd8;
  localparam logic [4:0] S_PT_INIT = 5'd9;
  localparam logic [4:0] S_PT      = 5'd10;
  localparam logic [4:0] S_D0      = 5'd11;
  localparam logic [4:0] S_D0C     = 5'd12;
  localparam logic [4:0] S_RS      = 5'd13;
  localparam logic [4:0] S_RA      = 5'd14;
  localparam logic [4:0] S_RB      = 5'd15;
  localparam logic [4:0] S_RC      = 5'd16;
  localparam logic [4:0] S_LM      = 5'd17;
  localparam logic [4:0] S_LD      = 5'd18;
  localparam logic [4:0] S_LW      = 5'd19;
  localparam logic [4:0] S_RM      = 5'd20;
  localparam logic [4:0] S_RD      = 5'd21;
  localparam logic [4:0] S_RW      = 5'd22;
  localparam logic [4:0] S_WR      = 5'd23;
  localparam logic [4:0] S_ACC     = 5'd24;
  localparam logic [4:0] S_AM      = 5'd25;
  localparam logic [4:0] S_AA      = 5'd26;
  localparam logic [4:0] S_OUT     = 5'd27;

  // Configuration registers.
  logic [2:0] deg_reg;
  logic [5:0] cnt_reg;

  // Sequencer state.
  logic [4:0]    state;
  logic          is_build;
  logic [TW-1:0] t_cur;
  logic [5:0]    seg_reg;
  logic [5:0]    smp;
  logic [KAW-1:0] kidx;
  logic [5:0]    pidx;
  logic [2:0]    jj;
  logic [2:0]    rr;
  logic [1:0]    ax;
  logic          any_nz;

  // Working values.
  logic [TW-1:0] w_arr [bspc_pkg::W_DEPTH];
  logic [TW-1:0] wlo, whi, wgt;
  logic [TW-1:0] k_a, k_r, k_a1, k_r1;
  logic [TW-1:0] lterm, rterm;
  logic [DW-1:0] bprod;
  logic signed [49:0] cprod;
  logic signed [AW-1:0] acc_arr [3];

  // Output register.
  logic               ov;
  logic signed [31:0] ox, oy, oz;
  logic               odeg, olast;

  // Memories and their ports.
  bspc_pkg::point_t pt_mem [bspc_pkg::MAX_POINTS];
  bspc_pkg::point_t pq;
  logic [PAW-1:0]   pt_raddr;
  logic             pt_we;
  logic [TW-1:0]    knot_mem [bspc_pkg::KNOT_DEPTH];
  logic [TW-1:0]    kqa, kqb;
  logic [KAW-1:0]   ka_addr, kb_addr;
  logic             kw_en;
  logic [TW-1:0]    kw_data;

  bspc_pkg::div_req_t div_req;
  bspc_pkg::div_rsp_t div_rsp;

  // Derived control values.
  logic [5:0]     n_eff, pw, m_idx, interior;
  logic           degen;
  logic           slot_free;
  logic           last_flag;
  logic [PAW-1:0] end_idx;
  logic           knot_const;
  logic [TW-1:0]  numl, numr;
  logic [TW:0]    wsum;
  logic [TW-1:0]  wnew;
  logic [TW-1:0]  qclip;
  logic signed [31:0] coord_sel;

  always_comb begin
    n_eff     = (cnt_reg > 6'(bspc_pkg::MAX_POINTS)) ? 6'(bspc_pkg::MAX_POINTS) : cnt_reg;
    pw        = {3'b000, deg_reg};
    m_idx     = n_eff + pw;
    interior  = n_eff - pw;
    degen     = n_eff <= pw;
    slot_free = !ov || res.ready;
    last_flag = !is_build || (smp == seg_reg);
    end_idx   = (t_cur == '0) ? '0 : PAW'(n_eff - 6'd1);
    knot_const = (kidx <= pw) || (kidx >= n_eff);
    numl      = (t_cur > k_a) ? TW'(t_cur - k_a) : '0;
    numr      = (k_r1 > t_cur) ? TW'(k_r1 - t_cur) : '0;
    wsum      = {1'b0, lterm} + {1'b0, rterm};
    wnew      = (wsum > {1'b0, bspc_pkg::ONE}) ? bspc_pkg::ONE : wsum[TW-1:0];
    qclip     = (div_rsp.quot > DW'(bspc_pkg::ONE)) ? bspc_pkg::ONE : div_rsp.quot[TW-1:0];
    case (ax)
      2'd0:    coord_sel = pq.x;
      2'd1:    coord_sel = pq.y;
      default: coord_sel = pq.z;
    endcase
  end

  // Knot store read addresses follow the step of the basis triangle.
  always_comb begin
    case (state)
      S_D0: begin
        ka_addr = KAW'(pidx + 6'(jj));
        kb_addr = KAW'(pidx + 6'(jj) + 6'd1);
      end
      S_RA: begin
        ka_addr = KAW'(pidx + 6'(jj));
        kb_addr = KAW'(pidx + 6'(jj) + 6'(rr));
      end
      S_RB: begin
        ka_addr = KAW'(pidx + 6'(jj) + 6'd1);
        kb_addr = KAW'(pidx + 6'(jj) + 6'(rr) + 6'd1);
      end
      default: begin
        ka_addr = '0;
        kb_addr = '0;
      end
    endcase
  end

  // Knot store writes during the rebuild.
  always_comb begin
    kw_en   = 1'b0;
    kw_data = '0;
    if (state == S_KNOT && kidx <= m_idx && knot_const) begin
      kw_en   = 1'b1;
      kw_data = (kidx <= pw) ? '0 : bspc_pkg::ONE;
    end else if (state == S_KNOT_W && div_rsp.done) begin
      kw_en   = 1'b1;
      kw_data = div_rsp.quot[TW-1:0];
    end
  end

  // Divider requests: interior knots, build sample times and basis terms.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state)
      S_KNOT: begin
        div_req.start    = (kidx <= m_idx) && !knot_const;
        div_req.dividend = (DW'(kidx - pw) << bspc_pkg::FRAC_BITS) + DW'(interior >> 1);
        div_req.divisor  = SW'(interior);
      end
      S_TDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = (DW'(smp) << bspc_pkg::FRAC_BITS) + DW'(seg_reg >> 1);
        div_req.divisor  = SW'(seg_reg);
      end
      S_LD: begin
        div_req.start    = 1'b1;
        div_req.dividend = bprod;
        div_req.divisor  = SW'(k_r - k_a);
      end
      S_RD: begin
        div_req.start    = 1'b1;
        div_req.dividend = bprod;
        div_req.divisor  = SW'(k_r1 - k_a1);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  bspc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Point store: written by write requests in idle, read during evaluation.
  assign pt_we    = cmd.valid && cmd.ready && (cmd.req_type == bspc_pkg::REQ_WRITE);
  assign pt_raddr = (state == S_END_RD || state == S_END_OUT) ? end_idx : pidx[PAW-1:0];

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[cmd.point_index] <= '{x: cmd.point_x, y: cmd.point_y, z: cmd.point_z};
    end
    pq <= pt_mem[pt_raddr];
  end

  // Knot store, two read ports.
  always_ff @(posedge clk) begin
    if (kw_en) begin
      knot_mem[kidx] <= kw_data;
    end
    kqa <= knot_mem[ka_addr];
    kqb <= knot_mem[kb_addr];
  end

  // Configuration port.
  assign pready = 1'b1;

  always_comb begin
    case (paddr[2])
      bspc_pkg::REG_COUNT: prdata = {26'd0, cnt_reg};
      default:             prdata = {29'd0, deg_reg};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deg_reg <= 3'd3;
      cnt_reg <= 6'd0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        bspc_pkg::REG_DEGREE: deg_reg <= pwdata[2:0];
        bspc_pkg::REG_COUNT:  cnt_reg <= pwdata[5:0];
        default:              cnt_reg <= cnt_reg;
      endcase
    end
  end

  assign cmd.ready = (state == S_IDLE);

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ov    <= 1'b0;
    end else begin
      if (ov && res.ready) begin
        ov <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            case (cmd.req_type)
              bspc_pkg::REQ_EVAL: begin
                is_build <= 1'b0;
                t_cur    <= cmd.param_t;
                state    <= S_EVAL;
              end
              bspc_pkg::REQ_BUILD: begin
                if (cmd.segments != 6'd0 && !degen) begin
                  is_build <= 1'b1;
                  seg_reg  <= cmd.segments;
                  smp      <= 6'd0;
                  kidx     <= '0;
                  state    <= S_KNOT;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end

        // Rebuild the knot vector, one entry per step.
        S_KNOT: begin
          if (kidx > m_idx) begin
            state <= is_build ? S_TDIV : S_PT_INIT;
          end else if (knot_const) begin
            kidx <= kidx + KAW'(1);
          end else begin
            state <= S_KNOT_W;
          end
        end
        S_KNOT_W: begin
          if (div_rsp.done) begin
            kidx  <= kidx + KAW'(1);
            state <= S_KNOT;
          end
        end

        // Sample time of a build.
        S_TDIV: state <= S_TWAIT;
        S_TWAIT: begin
          if (div_rsp.done) begin
            t_cur <= div_rsp.quot[TW-1:0];
            state <= S_EVAL;
          end
        end

        // Pick the special cases before the full evaluation.
        S_EVAL: begin
          if (degen) begin
            state <= S_DEG;
          end else if (t_cur == '0 || t_cur >= bspc_pkg::ONE) begin
            state <= S_END_RD;
          end else if (is_build) begin
            state <= S_PT_INIT;
          end else begin
            kidx  <= '0;
            state <= S_KNOT;
          end
        end

        S_DEG: begin
          if (slot_free) begin
            ov    <= 1'b1;
            ox    <= '0;
            oy    <= '0;
            oz    <= '0;
            odeg  <= 1'b1;
            olast <= 1'b1;
            state <= S_IDLE;
          end
        end

        S_END_RD: state <= S_END_OUT;
        S_END_OUT: begin
          if (slot_free) begin
            ov    <= 1'b1;
            ox    <= pq.x;
            oy    <= pq.y;
            oz    <= pq.z;
            odeg  <= 1'b0;
            olast <= last_flag;
            if (is_build && !last_flag) begin
              smp   <= smp + 6'd1;
              state <= S_TDIV;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        S_PT_INIT: begin
          pidx       <= 6'd0;
          acc_arr[0] <= '0;
          acc_arr[1] <= '0;
          acc_arr[2] <= '0;
          state      <= S_PT;
        end

        S_PT: begin
          if (pidx == n_eff) begin
            state <= S_OUT;
          end else begin
            jj     <= 3'd0;
            any_nz <= 1'b0;
            state  <= S_D0;
          end
        end

        // Degree-0 weights from the knot pairs.
        S_D0: state <= S_D0C;
        S_D0C: begin
          w_arr[jj] <= ((kqa <= t_cur) && (t_cur < kqb)) ? bspc_pkg::ONE : '0;
          any_nz    <= any_nz || ((kqa <= t_cur) && (t_cur < kqb));
          if (jj == deg_reg) begin
            if (!(any_nz || ((kqa <= t_cur) && (t_cur < kqb)))) begin
              pidx  <= pidx + 6'd1;
              state <= S_PT;
            end else if (deg_reg == 3'd0) begin
              state <= S_ACC;
            end else begin
              rr    <= 3'd1;
              jj    <= 3'd0;
              state <= S_RS;
            end
          end else begin
            jj    <= jj + 3'd1;
            state <= S_D0;
          end
        end

        // One raise of the triangle: fetch knots and neighbouring weights.
        S_RS: begin
          wlo   <= w_arr[0];
          state <= S_RA;
        end
        S_RA: begin
          whi   <= w_arr[jj + 3'd1];
          state <= S_RB;
        end
        S_RB: begin
          k_a   <= kqa;
          k_r   <= kqb;
          state <= S_RC;
        end
        S_RC: begin
          k_a1  <= kqa;
          k_r1  <= kqb;
          state <= S_LM;
        end

        // Left term.
        S_LM: begin
          if (k_r > k_a && wlo != '0) begin
            bprod <= DW'(numl) * DW'(wlo);
            state <= S_LD;
          end else begin
            lterm <= '0;
            state <= S_RM;
          end
        end
        S_LD: state <= S_LW;
        S_LW: begin
          if (div_rsp.done) begin
            lterm <= qclip;
            state <= S_RM;
          end
        end

        // Right term.
        S_RM: begin
          if (k_r1 > k_a1 && whi != '0) begin
            bprod <= DW'(numr) * DW'(whi);
            state <= S_RD;
          end else begin
            rterm <= '0;
            state <= S_WR;
          end
        end
        S_RD: state <= S_RW;
        S_RW: begin
          if (div_rsp.done) begin
            rterm <= qclip;
            state <= S_WR;
          end
        end

        // Store the raised weight and move along the row.
        S_WR: begin
          w_arr[jj] <= wnew;
          wlo       <= whi;
          if ({1'b0, jj} + {1'b0, rr} == {1'b0, deg_reg}) begin
            if (rr == deg_reg) begin
              state <= S_ACC;
            end else begin
              rr    <= rr + 3'd1;
              jj    <= 3'd0;
              state <= S_RS;
            end
          end else begin
            jj    <= jj + 3'd1;
            state <= S_RA;
          end
        end

        // Weighted sum, one axis per multiply.
        S_ACC: begin
          wgt <= w_arr[0];
          if (w_arr[0] == '0) begin
            pidx  <= pidx + 6'd1;
            state <= S_PT;
          end else begin
            ax    <= 2'd0;
            state <= S_AM;
          end
        end
        S_AM: begin
          cprod <= coord_sel * $signed({1'b0, wgt});
          state <= S_AA;
        end
        S_AA: begin
          acc_arr[ax] <= acc_arr[ax] + AW'(cprod);
          if (ax == 2'd2) begin
            pidx  <= pidx + 6'd1;
            state <= S_PT;
          end else begin
            ax    <= ax + 2'd1;
            state <= S_AM;
          end
        end

        S_OUT: begin
          if (slot_free) begin
            ov    <= 1'b1;
            ox    <= bspc_pkg::finish_coord(acc_arr[0]);
            oy    <= bspc_pkg::finish_coord(acc_arr[1]);
            oz    <= bspc_pkg::finish_coord(acc_arr[2]);
            odeg  <= 1'b0;
            olast <= last_flag;
            if (is_build && !last_flag) begin
              smp   <= smp + 6'd1;
              state <= S_TDIV;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid      = ov;
  assign res.curve_x    = ox;
  assign res.curve_y    = oy;
  assign res.curve_z    = oz;
  assign res.degenerate = odeg;
  assign res.last       = olast;

  `include "bspline_curve_evaluator_core_assert.svh"

  // A degenerate result is the final one and carries the zero point.
  `BSPC_ASSERT_NOW(a_degen_zero, res.valid && res.degenerate, res.last && res.curve_x == 32'sd0 && res.curve_y == 32'sd0 && res.curve_z == 32'sd0)
  // The shared divider is only started when it is free.
  `BSPC_ASSERT_NOW(a_div_free, div_req.start, !div_rsp.busy)
  // An accepted evaluate always leaves idle.
  `BSPC_ASSERT_NEXT(a_eval_busy, cmd.valid && cmd.ready && cmd.req_type == bspc_pkg::REQ_EVAL, state != S_IDLE)

endmodule

// ----- tb/bspline_curve_evaluator_core_tb.sv -----
module bspline_curve_evaluator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bspc_pkg::*;

  localparam logic [1:0] REQ_IGNORED = 2'd3;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int IDLE_TAIL = 2000;
  localparam int LONG_HOLD = 3000;
  localparam int ONE_VAL = 1 << FRAC_BITS;

  typedef struct {
    logic [1:0]         kind;
    logic [4:0]         slot;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [16:0]        t;
    logic [5:0]         seg;
  } request_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               degen;
    logic               last;
  } curve_pt_t;

  // Predicts curve points from its own copy of the point store and registers.
  class curve_scoreboard;
    int unsigned degree_reg;
    int unsigned count_reg;
    logic signed [31:0] px[MAX_POINTS];
    logic signed [31:0] py[MAX_POINTS];
    logic signed [31:0] pz[MAX_POINTS];
    longint knots[KNOT_DEPTH];
    longint weights[W_DEPTH];
    curve_pt_t expected_pts[$];
    int mismatches;

    function new();
      degree_reg = 3;
      count_reg = 0;
      mismatches = 0;
    endfunction

    function int unsigned used_count();
      return (count_reg > MAX_POINTS) ? MAX_POINTS : count_reg;
    endfunction

    function int unsigned used_degree();
      return (degree_reg > MAX_DEGREE) ? MAX_DEGREE : degree_reg;
    endfunction

    // Clamped knot vector with rounded uniform interior knots.
    function void make_knots(int unsigned n, int unsigned p);
      int unsigned inner;
      inner = n - p;
      foreach (knots[k]) knots[k] = 0;
      for (int unsigned i = 1; i < inner; i++)
        knots[p + i] = (longint'(i) * ONE_VAL + longint'(inner / 2)) / longint'(inner);
      for (int unsigned i = n; i <= n + p; i++) knots[i] = ONE_VAL;
    endfunction

    // Cox-de Boor triangle for the basis weight of point a0.
    function longint basis_weight(int unsigned a0, int unsigned p, longint t);
      longint lft, rgt, num, d1, d2, total;
      for (int unsigned j = 0; j <= p; j++)
        weights[j] = (knots[a0 + j] <= t && t < knots[a0 + j + 1]) ? ONE_VAL : 0;
      for (int unsigned r = 1; r <= p; r++) begin
        for (int unsigned j = 0; j + r <= p; j++) begin
          lft = 0;
          rgt = 0;
          d1 = knots[a0 + j + r] - knots[a0 + j];
          d2 = knots[a0 + j + r + 1] - knots[a0 + j + 1];
          if (d1 > 0) begin
            num = t - knots[a0 + j];
            if (num < 0) num = 0;
            lft = num * weights[j] / d1;
          end
          if (d2 > 0) begin
            num = knots[a0 + j + r + 1] - t;
            if (num < 0) num = 0;
            rgt = num * weights[j + 1] / d2;
          end
          total = lft + rgt;
          weights[j] = (total > ONE_VAL) ? ONE_VAL : total;
        end
      end
      return weights[0];
    endfunction

    function longint sum_clip(longint a, longint b);
      longint s;
      s = a + b;
      if (s > (64'sd1 <<< 62)) s = 64'sd1 <<< 62;
      if (s < -(64'sd1 <<< 62)) s = -(64'sd1 <<< 62);
      return s;
    endfunction

    // Floor division by one, then saturation to 32 bits signed.
    function logic signed [31:0] to_coord(longint acc);
      longint q;
      q = acc >>> FRAC_BITS;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q[31:0];
    endfunction

    function curve_pt_t point_at(longint t, logic last_flag);
      curve_pt_t pt;
      int unsigned n, p, k;
      longint ax, ay, az, w;
      n = used_count();
      p = used_degree();
      pt.degen = 1'b0;
      pt.last = last_flag;
      if (n <= p) begin
        pt.x = 0;
        pt.y = 0;
        pt.z = 0;
        pt.degen = 1'b1;
        return pt;
      end
      if (t <= 0 || t >= ONE_VAL) begin
        k = (t <= 0) ? 0 : n - 1;
        pt.x = px[k];
        pt.y = py[k];
        pt.z = pz[k];
        return pt;
      end
      make_knots(n, p);
      ax = 0;
      ay = 0;
      az = 0;
      for (int unsigned i = 0; i < n; i++) begin
        w = basis_weight(i, p, t);
        ax = sum_clip(ax, longint'(px[i]) * w);
        ay = sum_clip(ay, longint'(py[i]) * w);
        az = sum_clip(az, longint'(pz[i]) * w);
      end
      pt.x = to_coord(ax);
      pt.y = to_coord(ay);
      pt.z = to_coord(az);
      return pt;
    endfunction

    // Called for every accepted item: updates the store or queues curve points.
    function void note_input(request_t it);
      longint t;
      case (it.kind)
        REQ_WRITE: begin
          px[it.slot] = it.x;
          py[it.slot] = it.y;
          pz[it.slot] = it.z;
        end
        REQ_EVAL: begin
          expected_pts.push_back(point_at(longint'(it.t), 1'b1));
        end
        REQ_BUILD: begin
          if (it.seg != 0 && used_count() > used_degree()) begin
            for (int unsigned i = 0; i <= it.seg; i++) begin
              t = (longint'(i) * ONE_VAL + longint'(it.seg / 2)) / longint'(it.seg);
              expected_pts.push_back(point_at(t, i == it.seg));
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(curve_pt_t got);
      curve_pt_t exp_pt;
      if (expected_pts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected curve point x=%0d y=%0d z=%0d degen=%0b last=%0b",
                   got.x, got.y, got.z, got.degen, got.last);
        return;
      end
      exp_pt = expected_pts.pop_front();
      if (got.x !== exp_pt.x || got.y !== exp_pt.y || got.z !== exp_pt.z ||
          got.degen !== exp_pt.degen || got.last !== exp_pt.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Point mismatch: expected %0d %0d %0d d%0b l%0b, got %0d %0d %0d d%0b l%0b",
                   exp_pt.x, exp_pt.y, exp_pt.z, exp_pt.degen, exp_pt.last,
                   got.x, got.y, got.z, got.degen, got.last);
      end
    endfunction

    function int pending();
      return expected_pts.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  bspc_req_if cmd_bus ();
  bspc_rsp_if res_bus ();

  curve_scoreboard sb;
  bit written[MAX_POINTS];
  bit quiet;
  bit hold_req;
  int unsigned cycles;

  bspline_curve_evaluator_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_bus),
    .res     (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock, 8 ns period.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result monitor: every accepted item on the result side is checked.
  always @(posedge clk) begin
    curve_pt_t got;
    if (!rst && res_bus.valid && res_bus.ready) begin
      got.x = res_bus.curve_x;
      got.y = res_bus.curve_y;
      got.z = res_bus.curve_z;
      got.degen = res_bus.degenerate;
      got.last = res_bus.last;
      sb.check_result(got);
    end
  end

  // Receiver: random stalls per item, and one long hold-off on request.
  initial begin
    int stall;
    res_bus.ready = 1'b0;
    forever begin
      if (hold_req) begin
        res_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = quiet ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk); while (!res_bus.valid);
    end
  end

  // Register write over the configuration port; the predictor follows it.
  task automatic reg_write(logic reg_sel, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (reg_sel == REG_DEGREE) sb.degree_reg = value[2:0];
    else sb.count_reg = value[5:0];
  endtask

  // Wait until every curve point is back and the block has gone quiet.
  task automatic drain();
    while (sb.pending() > 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  task automatic set_curve(int unsigned deg, int unsigned cnt);
    drain();
    reg_write(REG_DEGREE, deg);
    reg_write(REG_COUNT, cnt);
  endtask

  // Offer one item after a random gap and hold it until it is accepted.
  task automatic send_item(request_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.req_type <= it.kind;
    cmd_bus.point_index <= it.slot;
    cmd_bus.point_x <= it.x;
    cmd_bus.point_y <= it.y;
    cmd_bus.point_z <= it.z;
    cmd_bus.param_t <= it.t;
    cmd_bus.segments <= it.seg;
    cmd_bus.valid <= 1'b1;
    do @(posedge clk); while (!cmd_bus.ready);
    sb.note_input(it);
    if (it.kind == REQ_WRITE) written[it.slot] = 1'b1;
  endtask

  task automatic send_req(logic [1:0] kind, logic [4:0] slot, logic signed [31:0] x,
                          logic signed [31:0] y, logic signed [31:0] z,
                          logic [16:0] t, logic [5:0] seg);
    request_t it;
    it.kind = kind;
    it.slot = slot;
    it.x = x;
    it.y = y;
    it.z = z;
    it.t = t;
    it.seg = seg;
    send_item(it);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 32'h0003FFFF)) - 32'sd131072;
      default: return $urandom();
    endcase
  endfunction

  // Random item; reads of unwritten slots are turned into writes.
  function automatic request_t rand_item(bit heavy);
    request_t it;
    int unsigned n, p, sel, first_free;
    bit all_set;
    n = sb.used_count();
    p = sb.used_degree();
    all_set = 1'b1;
    first_free = 0;
    for (int i = MAX_POINTS - 1; i >= 0; i--) begin
      if (!written[i]) first_free = i;
      if (!written[i] && i < n) all_set = 1'b0;
    end
    it.slot = $urandom_range(0, MAX_POINTS - 1);
    it.x = rand_coord();
    it.y = rand_coord();
    it.z = rand_coord();
    case ($urandom_range(0, 3))
      0: it.t = 0;
      1: it.t = $urandom_range(ONE_VAL, 17'h1FFFF);
      default: it.t = $urandom_range(1, ONE_VAL - 1);
    endcase
    if (heavy) it.seg = $urandom_range(0, 1);
    else if ($urandom_range(0, 7) == 0) it.seg = (p <= 2) ? 6'd63 : 6'd0;
    else it.seg = $urandom_range(1, 10);
    sel = $urandom_range(0, 99);
    if (sel < 30) it.kind = REQ_WRITE;
    else if (sel < 70) it.kind = REQ_EVAL;
    else if (sel < 93) it.kind = REQ_BUILD;
    else it.kind = REQ_IGNORED;
    if ((it.kind == REQ_EVAL || it.kind == REQ_BUILD) && n > p && !all_set) begin
      it.kind = REQ_WRITE;
      it.slot = first_free;
    end
    if (it.kind == REQ_WRITE && !written[first_free] && $urandom_range(0, 3) == 0)
      it.slot = first_free;
    return it;
  endfunction

  task automatic run_phase(int unsigned deg, int unsigned cnt, int items,
                           bit long_stall, bit pause_mid);
    bit heavy;
    heavy = (deg >= 5);
    set_curve(deg, cnt);
    quiet = ($urandom_range(0, 3) == 0);
    if (long_stall) hold_req = 1'b1;
    for (int i = 0; i < items; i++) begin
      if (pause_mid && i == items / 2) begin
        cmd_bus.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0) @(posedge clk);
      end
      send_item(rand_item(heavy));
    end
    cmd_bus.valid <= 1'b0;
    quiet = 1'b0;
  endtask

  initial begin
    sb = new();
    cycles = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cmd_bus.valid = 1'b0;
    cmd_bus.req_type = REQ_WRITE;
    cmd_bus.point_index = '0;
    cmd_bus.point_x = '0;
    cmd_bus.point_y = '0;
    cmd_bus.point_z = '0;
    cmd_bus.param_t = '0;
    cmd_bus.segments = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: too few points after reset, an ignored request, extreme writes.
    send_req(REQ_EVAL, 0, 0, 0, 0, 0, 0);
    send_req(REQ_BUILD, 0, 0, 0, 0, 0, 7);
    send_req(REQ_IGNORED, 5'd31, -1, -1, -1, 17'h1FFFF, 6'd63);
    send_req(REQ_WRITE, 0, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0);
    send_req(REQ_WRITE, 1, 32'sh80000000, 32'sh7FFFFFFF, -1, 0, 0);
    send_req(REQ_WRITE, 2, 32'sh12345678, -65536, 65536, 0, 0);
    send_req(REQ_WRITE, 3, -1, 0, 32'sh7FFFFFFF, 0, 0);
    send_req(REQ_WRITE, 5'd31, rand_coord(), rand_coord(), rand_coord(), 0, 0);
    cmd_bus.valid <= 1'b0;

    // Directed: the ends of the parameter range, interior points and builds.
    set_curve(3, 4);
    send_req(REQ_EVAL, 0, 0, 0, 0, 0, 0);
    send_req(REQ_EVAL, 0, 0, 0, 0, ONE_VAL, 0);
    send_req(REQ_EVAL, 0, 0, 0, 0, 17'h1FFFF, 0);
    send_req(REQ_EVAL, 0, 0, 0, 0, 1, 0);
    send_req(REQ_EVAL, 0, 0, 0, 0, ONE_VAL - 1, 0);
    send_req(REQ_EVAL, 0, 0, 0, 0, ONE_VAL / 2, 0);
    send_req(REQ_BUILD, 0, 0, 0, 0, 0, 0);
    send_req(REQ_BUILD, 0, 0, 0, 0, 0, 1);
    send_req(REQ_BUILD, 0, 0, 0, 0, 0, 63);
    cmd_bus.valid <= 1'b0;

    // Random phases over a spread of degrees and point counts.
    run_phase(0, 1, 40, 1'b0, 1'b0);
    run_phase(1, 2, 45, 1'b1, 1'b0);
    run_phase(2, 6, 45, 1'b0, 1'b1);
    run_phase(7, 8, 10, 1'b0, 1'b0);
    run_phase(1, 63, 45, 1'b0, 1'b0);
    run_phase(5, 12, 10, 1'b0, 1'b0);
    run_phase(4, 4, 30, 1'b0, 1'b0);
    run_phase(3, 10, 40, 1'b0, 1'b0);
    run_phase(7, 32, 8, 1'b0, 1'b0);
    run_phase(0, 32, 40, 1'b0, 1'b0);

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
